/* sv/plel_pkg.sv */
package plel_pkg;

  // Field and datapath widths
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 4;
  localparam int MAX_POINTS = 1 << IDX_W;
  localparam int CNT_W      = 5;
  localparam int FRAC_BITS  = 16;
  localparam int MAG_W      = DATA_W + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int NQ_W       = MAG_W + FRAC_BITS;
  localparam int SC_W       = PROD_W - FRAC_BITS + 1;
  localparam int STEP_W     = 7;
  localparam int CFG_IDX_W  = 2;

  // Shared unit operations
  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  // Request commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = CFG_IDX_W'(2);

  localparam logic [DATA_W-1:0] RANGE_HIGH_RST = DATA_W'(1) << FRAC_BITS;

  // Command to the shift-add / shift-subtract unit
  typedef struct packed {
    logic              go;
    logic              op;
    logic [PROD_W-1:0] opa;    // divide: dividend bits, left aligned
    logic [MAG_W-1:0]  opb;    // multiplicand or divisor
    logic [MAG_W-1:0]  opc;    // multiplier or initial remainder
    logic [STEP_W-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] res;
  } alu_rsp_t;

endpackage

/* sv/plel_alu.sv */
module plel_alu import plel_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic              op_r;
  logic [MAG_W-1:0]  b_r;
  logic [MAG_W-1:0]  rem_r;
  logic [PROD_W-1:0] sh_r;

  logic [MAG_W:0] mul_sum;
  logic [MAG_W:0] div_t;
  logic [MAG_W:0] div_sub;
  logic           div_ge;

  // One bit of multiply or divide per cycle
  always_comb begin
    mul_sum = {1'b0, rem_r} + (sh_r[0] ? {1'b0, b_r} : '0);
    div_t   = {rem_r, sh_r[PROD_W-1]};
    div_ge  = (div_t >= {1'b0, b_r});
    div_sub = div_t - {1'b0, b_r};
  end

  // Control: load on go, count down the steps, flag the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the partial product or the partial remainder
  always_ff @(posedge clk) begin
    if (req.go) begin
      op_r <= req.op;
      b_r  <= req.opb;
      if (req.op == ALU_MUL) begin
        rem_r <= '0;
        sh_r  <= PROD_W'(req.opc);
      end else begin
        rem_r <= req.opc;
        sh_r  <= req.opa;
      end
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        rem_r <= mul_sum[MAG_W:1];
        sh_r  <= {mul_sum[0], sh_r[PROD_W-1:1]};
      end else begin
        rem_r <= div_ge ? div_sub[MAG_W-1:0] : div_t[MAG_W-1:0];
        sh_r  <= {sh_r[PROD_W-2:0], div_ge};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = (op_r == ALU_MUL) ? {rem_r, sh_r[PROD_W-1:MAG_W]} : sh_r;

endmodule

/* sv/piecewise_linear_envelope_lookup_core.sv */
// Write request: accepted while idle, no result. Evaluate request: one at a time (straight
// to the result for an empty table); the next request is taken in the cycle after the
// result register loads. Evaluation uses the shared one-bit-per-cycle unit (33-step
// multiply and divide for interpolation, 49-step divide for normalization, 33-step
// multiply for rescaling) after a search of the breakpoints.
// Synchronous active-low reset clears control and configuration; point tables are not cleared.
module piecewise_linear_envelope_lookup_core import plel_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [IDX_W-1:0]     in_point_index,
  input  logic [DATA_W-1:0]    in_point_position,
  input  logic [DATA_W-1:0]    in_point_level,
  input  logic [DATA_W-1:0]    in_query_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_normalized_level,
  output logic [DATA_W-1:0]    out_scaled_level,
  output logic [IDX_W-1:0]     out_segment_index,
  output logic                 out_table_empty,
  output logic                 out_saturated,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE  = ST_W'(0);
  localparam logic [ST_W-1:0] S_SRCH  = ST_W'(1);
  localparam logic [ST_W-1:0] S_CMP   = ST_W'(2);
  localparam logic [ST_W-1:0] S_FET0  = ST_W'(3);
  localparam logic [ST_W-1:0] S_FET1  = ST_W'(4);
  localparam logic [ST_W-1:0] S_FET2  = ST_W'(5);
  localparam logic [ST_W-1:0] S_SIGN  = ST_W'(6);
  localparam logic [ST_W-1:0] S_CLASS = ST_W'(7);
  localparam logic [ST_W-1:0] S_IMUL  = ST_W'(8);
  localparam logic [ST_W-1:0] S_IDIV  = ST_W'(9);
  localparam logic [ST_W-1:0] S_NORM0 = ST_W'(10);
  localparam logic [ST_W-1:0] S_NORM1 = ST_W'(11);
  localparam logic [ST_W-1:0] S_NGO   = ST_W'(12);
  localparam logic [ST_W-1:0] S_NDIV  = ST_W'(13);
  localparam logic [ST_W-1:0] S_SGO   = ST_W'(14);
  localparam logic [ST_W-1:0] S_SMUL  = ST_W'(15);
  localparam logic [ST_W-1:0] S_SADD  = ST_W'(16);
  localparam logic [ST_W-1:0] S_OUT   = ST_W'(17);

  localparam logic [MAG_W-1:0]  NMAG_POS = MAG_W'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0]  NMAG_NEG = MAG_W'(64'd1 << (DATA_W - 1));
  localparam logic [DATA_W-1:0] INT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] INT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration
  logic [CNT_W-1:0]  point_count_r;
  logic [DATA_W-1:0] range_low_r;
  logic [DATA_W-1:0] range_high_r;

  // Point tables
  logic [DATA_W-1:0] pos_mem [MAX_POINTS];
  logic [DATA_W-1:0] lvl_mem [MAX_POINTS];
  logic [DATA_W-1:0] pos_q;
  logic [DATA_W-1:0] lvl_q;
  logic [IDX_W-1:0]  rd_addr;

  // Sequencer and working registers
  logic [ST_W-1:0]   state_r, state_nxt;
  logic [CNT_W-1:0]  n_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  k_r;
  logic [DATA_W-1:0] query_r;
  logic [DATA_W-1:0] d0_r, v0_r, v1_r;
  logic [MAG_W-1:0]  num_r, den_r, dv_r;
  logic              dv_neg_r;
  logic [DATA_W-1:0] level_r;
  logic [MAG_W-1:0]  span_r, diff_r;
  logic [MAG_W-1:0]  span_mag_r, dmag_r;
  logic              span_neg_r, nneg_r, sneg_r;
  logic [MAG_W-1:0]  nmag_r;
  logic [SC_W-1:0]   t_r;
  logic [DATA_W-1:0] norm_r, scaled_r;
  logic              empty_r, sat_r;

  // Result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_norm_r, out_scaled_r;
  logic [IDX_W-1:0]  out_seg_r;
  logic              out_empty_r, out_sat_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic             in_fire;
  logic [CNT_W-1:0] n_in;
  logic             srch_last;
  logic             srch_hit;
  logic             n_single;
  logic             out_load;

  logic [MAG_W:0]        lvl_sum;
  logic [NQ_W-1:0]       qm;
  logic                  q_ovf_pos, q_ovf_neg;
  logic [SC_W-2:0]       smag;
  logic [SC_W:0]         sc_sum;
  logic [SC_W-DATA_W+1:0] sc_hi;

  plel_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign n_in     = (point_count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count_r;
  assign n_single = (n_r == CNT_W'(1));
  assign srch_last = ({1'b0, i_r} == n_r - CNT_W'(2));
  assign srch_hit  = ($signed(query_r) <= $signed(pos_q));
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Arithmetic around the shared unit
  always_comb begin
    lvl_sum   = dv_neg_r ? ({{2{v0_r[DATA_W-1]}}, v0_r} - {1'b0, alu_rsp.res[MAG_W-1:0]})
                         : ({{2{v0_r[DATA_W-1]}}, v0_r} + {1'b0, alu_rsp.res[MAG_W-1:0]});
    qm        = alu_rsp.res[NQ_W-1:0];
    q_ovf_pos = |qm[NQ_W-1:DATA_W-1];
    q_ovf_neg = (|qm[NQ_W-1:DATA_W]) || (qm[DATA_W-1] && (|qm[DATA_W-2:0]));
    smag      = alu_rsp.res[PROD_W-1:FRAC_BITS];
    sc_sum    = {{(SC_W+1-DATA_W){range_low_r[DATA_W-1]}}, range_low_r}
              + {t_r[SC_W-1], t_r};
    sc_hi     = sc_sum[SC_W:DATA_W-1];
  end

  // Table read address by state
  always_comb begin
    case (state_r)
      S_SRCH:  rd_addr = i_r + IDX_W'(1);
      S_CMP:   rd_addr = i_r + IDX_W'(2);
      S_FET0:  rd_addr = k_r;
      S_FET1:  rd_addr = k_r + (n_single ? IDX_W'(0) : IDX_W'(1));
      default: rd_addr = k_r;
    endcase
  end

  // Issue work to the shared unit
  always_comb begin
    alu_req       = '0;
    alu_req.steps = STEP_W'(MAG_W);
    case (state_r)
      S_CLASS: begin
        if (!(den_r == '0 || $signed(num_r) <= 0) && !($signed(num_r) >= $signed(den_r))) begin
          alu_req.go  = 1'b1;
          alu_req.op  = ALU_MUL;
          alu_req.opb = dv_r;
          alu_req.opc = num_r;
        end
      end
      S_IMUL: begin
        if (alu_rsp.done) begin
          alu_req.go  = 1'b1;
          alu_req.op  = ALU_DIV;
          alu_req.opa = {alu_rsp.res[MAG_W-1:0], MAG_W'(0)};
          alu_req.opb = den_r;
          alu_req.opc = alu_rsp.res[PROD_W-1:MAG_W];
        end
      end
      S_NGO: begin
        if (span_mag_r != '0) begin
          alu_req.go    = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_req.opa   = {dmag_r, MAG_W'(0)};
          alu_req.opb   = span_mag_r;
          alu_req.opc   = '0;
          alu_req.steps = STEP_W'(NQ_W);
        end
      end
      S_SGO: begin
        alu_req.go  = 1'b1;
        alu_req.op  = ALU_MUL;
        alu_req.opb = span_mag_r;
        alu_req.opc = nmag_r;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_command == CMD_EVAL) begin
          if (n_in == '0)
            state_nxt = S_OUT;
          else if (n_in == CNT_W'(1))
            state_nxt = S_FET0;
          else
            state_nxt = S_SRCH;
        end
      end
      S_SRCH:  state_nxt = S_CMP;
      S_CMP:   if (srch_hit || srch_last) state_nxt = S_FET0;
      S_FET0:  state_nxt = S_FET1;
      S_FET1:  state_nxt = S_FET2;
      S_FET2:  state_nxt = S_SIGN;
      S_SIGN:  state_nxt = S_CLASS;
      S_CLASS: state_nxt = alu_req.go ? S_IMUL : S_NORM0;
      S_IMUL:  if (alu_rsp.done) state_nxt = S_IDIV;
      S_IDIV:  if (alu_rsp.done) state_nxt = S_NORM0;
      S_NORM0: state_nxt = S_NORM1;
      S_NORM1: state_nxt = S_NGO;
      S_NGO:   state_nxt = alu_req.go ? S_NDIV : S_SGO;
      S_NDIV:  if (alu_rsp.done) state_nxt = S_SGO;
      S_SGO:   state_nxt = S_SMUL;
      S_SMUL:  if (alu_rsp.done) state_nxt = S_SADD;
      S_SADD:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      point_count_r <= '0;
      range_low_r   <= '0;
      range_high_r  <= RANGE_HIGH_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: point_count_r <= cfg_wdata[CNT_W-1:0];
          REG_RANGE_LOW:   range_low_r   <= cfg_wdata;
          REG_RANGE_HIGH:  range_high_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Point tables: write on a write request, registered read
  always_ff @(posedge clk) begin
    if (in_fire && in_command == CMD_WRITE) begin
      pos_mem[in_point_index] <= in_point_position;
      lvl_mem[in_point_index] <= in_point_level;
    end
    pos_q <= pos_mem[rd_addr];
    lvl_q <= lvl_mem[rd_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        query_r <= in_query_position;
        n_r     <= n_in;
        i_r     <= '0;
        k_r     <= '0;
        empty_r <= (n_in == '0);
        norm_r  <= '0;
        scaled_r <= range_low_r;
        sat_r   <= 1'b0;
      end
      S_CMP: begin
        if (srch_hit || srch_last)
          k_r <= i_r;
        else
          i_r <= i_r + IDX_W'(1);
      end
      S_FET1: begin
        d0_r <= pos_q;
        v0_r <= lvl_q;
      end
      // Segment deltas against the start point
      S_FET2: begin
        v1_r  <= lvl_q;
        num_r <= {query_r[DATA_W-1], query_r} - {d0_r[DATA_W-1], d0_r};
        den_r <= {pos_q[DATA_W-1], pos_q} - {d0_r[DATA_W-1], d0_r};
        dv_r  <= {lvl_q[DATA_W-1], lvl_q} - {v0_r[DATA_W-1], v0_r};
      end
      // Make the width positive, take the level step magnitude
      S_SIGN: begin
        if (den_r[MAG_W-1]) begin
          num_r <= -num_r;
          den_r <= -den_r;
        end
        dv_neg_r <= dv_r[MAG_W-1];
        dv_r     <= dv_r[MAG_W-1] ? -dv_r : dv_r;
      end
      // Clamp to the segment ends or hold for the unit
      S_CLASS: begin
        if (den_r == '0 || $signed(num_r) <= 0)
          level_r <= v0_r;
        else if ($signed(num_r) >= $signed(den_r))
          level_r <= v1_r;
      end
      S_IDIV: begin
        if (alu_rsp.done)
          level_r <= lvl_sum[DATA_W-1:0];
      end
      S_NORM0: begin
        span_r <= {range_high_r[DATA_W-1], range_high_r} - {range_low_r[DATA_W-1], range_low_r};
        diff_r <= {level_r[DATA_W-1], level_r} - {range_low_r[DATA_W-1], range_low_r};
      end
      S_NORM1: begin
        span_neg_r <= span_r[MAG_W-1];
        span_mag_r <= span_r[MAG_W-1] ? -span_r : span_r;
        dmag_r     <= diff_r[MAG_W-1] ? -diff_r : diff_r;
        nneg_r     <= diff_r[MAG_W-1] ^ span_r[MAG_W-1];
      end
      // Empty range: normalized level is zero
      S_NGO: begin
        if (span_mag_r == '0) begin
          norm_r <= '0;
          sat_r  <= 1'b0;
          nmag_r <= '0;
          nneg_r <= 1'b0;
        end
      end
      // Sign and saturate the normalized level
      S_NDIV: begin
        if (alu_rsp.done) begin
          if (!nneg_r) begin
            sat_r  <= q_ovf_pos;
            norm_r <= q_ovf_pos ? INT_MAX : qm[DATA_W-1:0];
            nmag_r <= q_ovf_pos ? NMAG_POS : qm[MAG_W-1:0];
          end else begin
            sat_r  <= q_ovf_neg;
            norm_r <= q_ovf_neg ? INT_MIN : -qm[DATA_W-1:0];
            nmag_r <= q_ovf_neg ? NMAG_NEG : qm[MAG_W-1:0];
          end
        end
      end
      S_SGO: sneg_r <= span_neg_r ^ nneg_r;
      // Drop the fraction, truncating toward zero
      S_SMUL: begin
        if (alu_rsp.done)
          t_r <= sneg_r ? -{1'b0, smag} : {1'b0, smag};
      end
      S_SADD: begin
        if ((&sc_hi) || !(|sc_hi))
          scaled_r <= sc_sum[DATA_W-1:0];
        else
          scaled_r <= sc_sum[SC_W] ? INT_MIN : INT_MAX;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_norm_r   <= norm_r;
      out_scaled_r <= scaled_r;
      out_seg_r    <= k_r;
      out_empty_r  <= empty_r;
      out_sat_r    <= sat_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_normalized_level = out_norm_r;
  assign out_scaled_level     = out_scaled_r;
  assign out_segment_index    = out_seg_r;
  assign out_table_empty      = out_empty_r;
  assign out_saturated        = out_sat_r;

endmodule

/* tb/piecewise_linear_envelope_lookup_core_tb.sv */
module piecewise_linear_envelope_lookup_core_tb;
  import plel_pkg::*;

  localparam int     CLK_HALF     = 4;
  localparam int     RESET_CYCLES = 6;
  localparam int     DRAIN_CYCLES = 200;
  localparam int     HOLD_CYCLES  = 1500;
  localparam int     PHASE_ITEMS  = 70;
  localparam int     RAND_PHASES  = 12;
  localparam int     CYCLE_LIMIT  = 2000000;
  localparam longint ONE_Q        = longint'(1) << FRAC_BITS;
  localparam longint WORD_MAX     = 64'sd2147483647;
  localparam longint WORD_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] position;
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] query;
  } envelope_request_t;

  typedef struct packed {
    logic [DATA_W-1:0] normalized;
    logic [DATA_W-1:0] scaled;
    logic [IDX_W-1:0]  segment;
    logic              empty;
    logic              saturated;
  } envelope_result_t;

  logic                 clk                  = 1'b0;
  logic                 rst_n                = 1'b0;
  logic                 in_valid             = 1'b0;
  logic                 in_ready;
  logic                 in_command           = 1'b0;
  logic [IDX_W-1:0]     in_point_index       = '0;
  logic [DATA_W-1:0]    in_point_position    = '0;
  logic [DATA_W-1:0]    in_point_level       = '0;
  logic [DATA_W-1:0]    in_query_position    = '0;
  logic                 out_valid;
  logic                 out_ready            = 1'b0;
  logic [DATA_W-1:0]    out_normalized_level;
  logic [DATA_W-1:0]    out_scaled_level;
  logic [IDX_W-1:0]     out_segment_index;
  logic                 out_table_empty;
  logic                 out_saturated;
  logic                 cfg_we               = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index            = '0;
  logic [DATA_W-1:0]    cfg_wdata            = '0;

  // Pending requests, results still owed by the block
  envelope_request_t request_queue[$];
  envelope_result_t  expected_results[$];

  // Predictor copy of the breakpoint table and registers
  longint            point_pos[MAX_POINTS];
  longint            point_lvl[MAX_POINTS];
  logic [CNT_W-1:0]  model_count = '0;
  logic [DATA_W-1:0] model_low   = '0;
  logic [DATA_W-1:0] model_high  = RANGE_HIGH_RST;

  // Stimulus view of the envelope currently loaded
  logic [DATA_W-1:0] gen_pos[MAX_POINTS];
  int                gen_count = 0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_arm       = 1'b0;
  int   hold_left      = 0;
  int   cycle_count    = 0;
  int   error_count    = 0;

  envelope_request_t next_request;
  envelope_result_t  want;

  piecewise_linear_envelope_lookup_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_point_index       (in_point_index),
    .in_point_position    (in_point_position),
    .in_point_level       (in_point_level),
    .in_query_position    (in_query_position),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_normalized_level (out_normalized_level),
    .out_scaled_level     (out_scaled_level),
    .out_segment_index    (out_segment_index),
    .out_table_empty      (out_table_empty),
    .out_saturated        (out_saturated),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Envelope predictor
  // ---------------------------------------------------------------------------

  function automatic longint widen(input logic [DATA_W-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [DATA_W-1:0] clamp_to_word(input longint v, output logic clipped);
    clipped = 1'b0;
    if (v > WORD_MAX) begin
      clipped = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < WORD_MIN) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return DATA_W'(v);
  endfunction

  // Linear step inside one segment, truncated toward zero, held between its levels
  function automatic longint interp_level(input longint q, input longint d0, input longint d1,
                                          input longint v0, input longint v1);
    longint       num;
    longint       den;
    longint       dv;
    logic [63:0]  mag;
    logic [63:0]  incr;
    logic [127:0] prod;
    num = q - d0;
    den = d1 - d0;
    dv  = v1 - v0;
    if (den == 0) return v0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return v0;
    if (num >= den) return v1;
    mag  = (dv < 0) ? -dv : dv;
    prod = {64'd0, mag} * {64'd0, 64'(num)};
    incr = 64'(prod / {64'd0, 64'(den)});
    return (dv < 0) ? v0 - longint'(incr) : v0 + longint'(incr);
  endfunction

  function automatic envelope_result_t evaluate_envelope(input logic [DATA_W-1:0] query_bits);
    envelope_result_t r;
    int               n;
    int               k;
    int               k1;
    longint           q;
    longint           lvl;
    longint           low;
    longint           span;
    longint           norm;
    logic             clipped;
    logic             ignored;
    r   = '0;
    n   = (model_count > MAX_POINTS) ? MAX_POINTS : int'(model_count);
    low = widen(model_low);
    if (n == 0) begin
      r.scaled = model_low;
      r.empty  = 1'b1;
      return r;
    end
    // First segment whose end is at or above the query, else the last one
    q = widen(query_bits);
    k = n - 1;
    for (int i = 0; i + 1 < n; i++) begin
      k = i;
      if (q <= point_pos[i + 1]) break;
    end
    k1  = (k + 1 < n) ? k + 1 : n - 1;
    lvl = interp_level(q, point_pos[k], point_pos[k1], point_lvl[k], point_lvl[k1]);
    span    = widen(model_high) - low;
    clipped = 1'b0;
    norm    = 0;
    if (span != 0) begin
      r.normalized = clamp_to_word(((lvl - low) * ONE_Q) / span, clipped);
      norm         = widen(r.normalized);
    end
    r.scaled    = clamp_to_word(low + (span * norm) / ONE_Q, ignored);
    r.segment   = IDX_W'(k);
    r.saturated = clipped;
    return r;
  endfunction

  task automatic accept_request(input envelope_request_t req);
    if (req.command == CMD_WRITE) begin
      point_pos[req.index] = widen(req.position);
      point_lvl[req.index] = widen(req.level);
    end else begin
      expected_results = {expected_results, evaluate_envelope(req.query)};
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: present the next pending request, hold it until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accept_request({in_command, in_point_index, in_point_position, in_point_level,
                        in_query_position});
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_request      = request_queue.pop_front();
          in_valid          <= 1'b1;
          in_command        <= next_request.command;
          in_point_index    <= next_request.index;
          in_point_position <= next_request.position;
          in_point_level    <= next_request.level;
          in_query_position <= next_request.query;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (norm %h)",
                                    out_normalized_level));
        end else begin
          want = expected_results.pop_front();
          if (out_normalized_level !== want.normalized)
            report_mismatch($sformatf("normalized_level %h, want %h",
                                      out_normalized_level, want.normalized));
          if (out_scaled_level !== want.scaled)
            report_mismatch($sformatf("scaled_level %h, want %h",
                                      out_scaled_level, want.scaled));
          if (out_segment_index !== want.segment)
            report_mismatch($sformatf("segment_index %0d, want %0d",
                                      out_segment_index, want.segment));
          if (out_table_empty !== want.empty)
            report_mismatch($sformatf("table_empty %b, want %b",
                                      out_table_empty, want.empty));
          if (out_saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, want %b",
                                      out_saturated, want.saturated));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [DATA_W-1:0] rand_signed(input int bits);
    logic [DATA_W-1:0] v;
    v = $urandom;
    if (bits < DATA_W) v = DATA_W'(signed'(v << (DATA_W - bits)) >>> (DATA_W - bits));
    return v;
  endfunction

  // Append one request to the pending list
  task automatic enqueue_request(input envelope_request_t req);
    request_queue = {request_queue, req};
  endtask

  task automatic push_write(input int slot, input logic [DATA_W-1:0] pos,
                            input logic [DATA_W-1:0] lvl);
    enqueue_request({CMD_WRITE, IDX_W'(slot), pos, lvl, DATA_W'($urandom)});
  endtask

  task automatic push_eval(input logic [DATA_W-1:0] q);
    enqueue_request({CMD_EVAL, IDX_W'($urandom), DATA_W'($urandom),
                     DATA_W'($urandom), q});
  endtask

  // Overwrite one slot with arbitrary content
  task automatic push_noise_write();
    int                slot;
    logic [DATA_W-1:0] pos;
    slot = $urandom_range(MAX_POINTS - 1);
    pos  = $urandom;
    if (slot < gen_count) gen_pos[slot] = pos;
    push_write(slot, pos, $urandom);
  endtask

  // Fill slots 0..n-1 with ascending positions, now and then reversed
  task automatic load_envelope(input int n);
    longint stepmax;
    longint room;
    longint p;
    int     lvl_bits;
    int     slot;
    logic   descending;
    case ($urandom_range(4))
      0:       stepmax = 4;
      1:       stepmax = 4096;
      2:       stepmax = longint'(1) << 20;
      3:       stepmax = longint'(1) << 26;
      default: stepmax = longint'(1) << 27;
    endcase
    room       = (longint'(1) << 32) - n * stepmax;
    p          = WORD_MIN + (longint'($urandom) % room);
    lvl_bits   = $urandom_range(8, DATA_W);
    descending = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      slot          = descending ? n - 1 - i : i;
      gen_pos[slot] = DATA_W'(p);
      push_write(slot, DATA_W'(p), rand_signed(lvl_bits));
      p += longint'($urandom) % (stepmax + 1);
    end
  endtask

  // Query mostly inside or at the edges of the loaded envelope
  function automatic logic [DATA_W-1:0] rand_query();
    longint lo_p;
    longint hi_p;
    longint q;
    int     j;
    logic   ignored;
    if (gen_count < 1) return $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        if (gen_count >= 2) begin
          j    = $urandom_range(gen_count - 2);
          lo_p = widen(gen_pos[j]);
          hi_p = widen(gen_pos[j + 1]);
          if (hi_p < lo_p) begin
            q    = lo_p;
            lo_p = hi_p;
            hi_p = q;
          end
          q = lo_p + (longint'($urandom) % (hi_p - lo_p + 1));
        end else begin
          q = widen(gen_pos[0]);
        end
      end
      4, 5: begin
        j = $urandom_range(gen_count - 1);
        q = widen(gen_pos[j]) + (int'($urandom_range(2)) - 1);
      end
      6:       q = widen(gen_pos[0]) - int'($urandom_range(1000));
      7:       q = widen(gen_pos[gen_count - 1]) + int'($urandom_range(1000));
      8:       q = $urandom_range(1) ? WORD_MAX : WORD_MIN;
      default: return $urandom;
    endcase
    return clamp_to_word(q, ignored);
  endfunction

  task automatic pick_range(output logic [DATA_W-1:0] lo, output logic [DATA_W-1:0] hi);
    case ($urandom_range(6))
      0: begin
        lo = '0;
        hi = RANGE_HIGH_RST;
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = rand_signed(24);
        hi = lo;
      end
      3: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      4: begin
        lo = 32'h7fff_ffff;
        hi = 32'h8000_0000;
      end
      5: begin
        lo = rand_signed(20);
        hi = lo + $urandom_range(1, 256);
      end
      default: begin
        lo = rand_signed(21);
        hi = rand_signed(21);
      end
    endcase
  endtask

  // Wait until the block is idle with nothing owed
  task automatic drain();
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POINT_COUNT: model_count = CNT_W'(val);
      REG_RANGE_LOW:   model_low   = val;
      REG_RANGE_HIGH:  model_high  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int count, input logic [DATA_W-1:0] lo,
                            input logic [DATA_W-1:0] hi);
    write_reg(REG_POINT_COUNT, DATA_W'(count));
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
  endtask

  task automatic set_pace(input int mode);
    @(negedge clk);
    case (mode)
      1: begin
        send_idle_pct  = 62;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 62;
      end
      3: begin
        send_idle_pct  = 24;
        recv_stall_pct = 24;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] dir_pos[MAX_POINTS];
    logic [DATA_W-1:0] dir_lvl[MAX_POINTS];
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int                count;
    int                pick;

    // Ascending table: minimum position first, a zero-width pair at slots 13 and 14
    dir_pos = '{32'h8000_0000, 32'hc000_0000, 32'hffff_0000, 32'h0000_0000,
                32'h0001_0000, 32'h0010_0000, 32'h0100_0000, 32'h0400_0000,
                32'h0800_0000, 32'h1000_0000, 32'h2000_0000, 32'h3000_0000,
                32'h3800_0000, 32'h4000_0000, 32'h4000_0000, 32'h7fff_ffff};
    dir_lvl = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                32'hffff_0000, 32'h4000_0000, 32'hc000_0000, 32'h0000_0001,
                32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                32'h0001_e240, 32'hfff0_edba, 32'h0002_0000, 32'h8000_0000};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table at reset settings, then fill every slot
    set_pace(0);
    push_eval(32'h7fff_ffff);
    push_eval(32'h8000_0000);
    for (int i = 0; i < MAX_POINTS; i++) push_write(i, dir_pos[i], dir_lvl[i]);
    drain();

    // Single point over the widest range
    set_config(1, 32'h8000_0000, 32'h7fff_ffff);
    set_pace(1);
    push_eval(32'h0000_0000);
    drain();

    // Full table, unit range: both ends and a mid-segment query
    set_config(MAX_POINTS, '0, RANGE_HIGH_RST);
    set_pace(2);
    push_eval(32'h8000_0000);
    push_eval(32'h7fff_ffff);
    push_eval(32'h0000_8000);
    drain();

    // Last segment of zero width
    set_config(MAX_POINTS - 1, '0, RANGE_HIGH_RST);
    set_pace(3);
    push_eval(32'h4000_0005);
    drain();

    // Count beyond the table with an empty range
    set_config(31, 32'd12345, 32'd12345);
    push_eval($urandom);
    drain();

    // Span of one LSB: normalization clips both ways
    set_config(MAX_POINTS, '0, 32'd1);
    set_pace(0);
    push_eval(32'hc000_0000);
    push_eval(32'hffff_0000);
    drain();

    // Random phases over random settings and pacing
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(7))
        0:       count = 0;
        1:       count = 1;
        2:       count = MAX_POINTS;
        3:       count = $urandom_range(MAX_POINTS + 1, 31);
        default: count = $urandom_range(2, MAX_POINTS - 1);
      endcase
      pick_range(lo, hi);
      set_config(count, lo, hi);
      gen_count = (count > MAX_POINTS) ? MAX_POINTS : count;
      set_pace(p % 4);
      load_envelope(gen_count);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) push_eval(rand_query());
        else if (pick < 78) push_eval($urandom);
        else if (pick < 92 || gen_count == 0) push_noise_write();
        else load_envelope(gen_count);
      end
      drain();
    end

    // Block the receiver for a long stretch while requests keep coming
    set_config(MAX_POINTS, 32'h8000_0000, 32'h7fff_ffff);
    gen_count = MAX_POINTS;
    set_pace(0);
    load_envelope(gen_count);
    for (int k = 0; k < 30; k++) push_eval(rand_query());
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    drain();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/plel_pkg.sv
sv/plel_alu.sv
sv/piecewise_linear_envelope_lookup_core.sv
tb/piecewise_linear_envelope_lookup_core_tb.sv
